// ===== hdl/fcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcf_pkg
// Shared types, register codes and command codes of the floppy controller
// command FIFO.
// ----------------------------------------------------------------------------
package fcf_pkg;

   // Command/result byte store
   localparam int FIFO_DEPTH = 16;               // 9..16
   localparam int FIFO_AW    = 4;                // index wraps modulo 16
   localparam logic [FIFO_AW:0] FIFO_LIMIT = (FIFO_AW + 1)'(FIFO_DEPTH);

   // Access kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Port offsets
   localparam logic [2:0] PORT_DOR  = 3'd2;
   localparam logic [2:0] PORT_MSR  = 3'd4;
   localparam logic [2:0] PORT_FIFO = 3'd5;
   localparam logic [2:0] PORT_CCR  = 3'd7;

   // Command codes (low nibble of the first byte)
   localparam logic [3:0] OPC_READ_DATA = 4'h6;
   localparam logic [3:0] OPC_RECAL     = 4'h7;
   localparam logic [3:0] OPC_SENSE_INT = 4'h8;
   localparam logic [3:0] OPC_READ_ID   = 4'hA;
   localparam logic [3:0] OPC_SEEK      = 4'hF;

   // Main status values
   localparam logic [7:0] MSR_IDLE   = 8'h80;
   localparam logic [7:0] MSR_RESULT = 8'hC0;
   localparam logic [7:0] MSR_DONE   = 8'hA0;
   localparam logic [7:0] MSR_BUSY   = 8'h10;

   localparam logic [7:0] DOR_KEEP_MASK = 8'hFB;   // bit 2 is never stored
   localparam logic [7:0] MAX_SECTORS   = 8'd128;
   localparam logic [7:0] SECTOR_FIXED  = 8'd1;    // current sector never moves
   localparam logic [7:0] SIZE_CODE_512 = 8'd2;    // 512-byte sectors
   localparam logic [3:0] ID_RESULT_LEN = 4'd7;
   localparam logic [3:0] SENSE_RESULT_LEN = 4'd2;
   localparam logic [3:0] RECAL_RESULT_LEN = 4'd1;
   localparam logic [3:0] MAX_CMD_LEN   = 4'd9;

   typedef struct packed {
      logic       kind;
      logic [2:0] port_offset;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        irq_level;
      logic        dma_start;
      logic [31:0] dma_block;
      logic [7:0]  dma_count;
      logic        access_error;
   } rsp_type;

   // Command length in bytes; zero for an unknown code
   function automatic logic [3:0] cmd_length(input logic [3:0] code);
      logic [3:0] len;
      case (code)
         OPC_READ_DATA: len = MAX_CMD_LEN;
         OPC_RECAL:     len = 4'd2;
         OPC_SENSE_INT: len = 4'd1;
         OPC_READ_ID:   len = 4'd2;
         OPC_SEEK:      len = 4'd3;
         default:       len = 4'd0;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/fcf_lba.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcf_lba
// Linear block address: 36*cyl + 18*head + sector - 1, modulo 2^32.
// ----------------------------------------------------------------------------
module fcf_lba
   import fcf_pkg::*;
(
   input  wire logic [7:0]  cyl,
   input  wire logic [7:0]  head,
   input  wire logic [7:0]  sector,
   output logic      [31:0] lba
);

   logic [13:0] sum;   // at most 9180 + 4590 + 255

   // constant multiplies as shift-adds
   assign sum = {1'b0, cyl, 5'd0} + {4'd0, cyl, 2'd0}
              + {2'd0, head, 4'd0} + {5'd0, head, 1'b0}
              + {6'd0, sector};
   assign lba = {18'd0, sum} - 32'd1;

endmodule
`default_nettype wire

// ===== hdl/fcf_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcf_core
// Controller state and the per-access update: registers, command assembly,
// command execution and result building. State moves on step.
// ----------------------------------------------------------------------------
module fcf_core
   import fcf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   output rsp_type      result
);

   logic [7:0]         msr_ff, msr_in;
   logic [7:0]         dor_ff, dor_in;
   logic [7:0]         fifo_ff [FIFO_DEPTH];
   logic [7:0]         fifo_in [FIFO_DEPTH];
   logic [FIFO_AW-1:0] idx_ff, idx_in;
   logic [3:0]         len_ff, len_in;
   logic [7:0]         cyl_ff, cyl_in;
   logic [7:0]         head_ff, head_in;
   logic               irq_ff, irq_in;

   logic [7:0]         fwd [7];      // command bytes 0..6 with this write applied
   logic               fifo_wr;
   logic               idx_ok;
   logic [FIFO_AW-1:0] idx_inc;
   logic [3:0]         new_len;
   logic [3:0]         len_eff;
   logic [31:0]        lba;

   assign fifo_wr = (item.kind == KIND_WRITE) && (item.port_offset == PORT_FIFO);
   assign idx_ok  = {1'b0, idx_ff} < FIFO_LIMIT;
   assign idx_inc = idx_ff + 1'b1;
   assign new_len = cmd_length(item.write_data[3:0]);

   always_comb begin
      for (int k = 0; k < 7; k++) begin
         fwd[k] = (fifo_wr && idx_ff == FIFO_AW'(k)) ? item.write_data : fifo_ff[k];
      end
   end

   fcf_lba u_lba (
      .cyl    (fwd[2]),
      .head   (fwd[3]),
      .sector (fwd[4]),
      .lba    (lba)
   );

   always_comb begin
      msr_in  = msr_ff;
      dor_in  = dor_ff;
      fifo_in = fifo_ff;
      idx_in  = idx_ff;
      len_in  = len_ff;
      cyl_in  = cyl_ff;
      head_in = head_ff;
      irq_in  = irq_ff;
      len_eff = len_ff;
      result  = '0;

      if (item.kind == KIND_READ) begin
         case (item.port_offset)
            PORT_MSR: result.read_data = msr_ff;
            PORT_DOR: result.read_data = dor_ff;
            PORT_FIFO: begin
               result.read_data = idx_ok ? fifo_ff[idx_ff] : 8'd0;
               idx_in = idx_inc;
               if ({1'b0, idx_inc} >= {1'b0, len_ff} || idx_inc == '0) begin
                  msr_in = MSR_DONE;
                  idx_in = '0;
                  irq_in = 1'b0;
               end
            end
            default: result.access_error = 1'b1;
         endcase
      end else begin
         case (item.port_offset)
            PORT_DOR: begin
               if (!item.write_data[2]) begin
                  msr_in = MSR_IDLE;
                  idx_in = '0;
                  len_in = '0;
                  irq_in = 1'b1;
               end
               dor_in = item.write_data & DOR_KEEP_MASK;
            end
            PORT_FIFO: begin
               if (idx_ff == '0 && new_len == '0) begin
                  // unknown command code: byte dropped
                  result.access_error = 1'b1;
               end else begin
                  if (idx_ff == '0) begin
                     len_eff = new_len;
                     msr_in  = msr_ff | MSR_BUSY;
                  end
                  len_in = len_eff;
                  if (idx_ok) begin
                     fifo_in[idx_ff] = item.write_data;
                  end
                  idx_in = idx_inc;
                  if ({1'b0, idx_inc} >= {1'b0, len_eff} || idx_inc == '0) begin
                     case (fwd[0][3:0])
                        OPC_READ_DATA: begin
                           if (fwd[6] > MAX_SECTORS) begin
                              idx_in = '0;
                              len_in = '0;
                              msr_in = MSR_IDLE;
                              result.access_error = 1'b1;
                           end else begin
                              cyl_in  = fwd[2];
                              head_in = fwd[3];
                              result.dma_start = 1'b1;
                              result.dma_block = lba;
                              result.dma_count = fwd[6];
                              fifo_in[0] = 8'd0;
                              fifo_in[1] = 8'd0;
                              fifo_in[2] = 8'd0;
                              fifo_in[3] = fwd[2];
                              fifo_in[4] = fwd[3];
                              fifo_in[5] = SECTOR_FIXED;
                              fifo_in[6] = SIZE_CODE_512;
                              len_in = ID_RESULT_LEN;
                              idx_in = '0;
                              msr_in = MSR_RESULT;
                              irq_in = 1'b1;
                           end
                        end
                        OPC_RECAL: begin
                           cyl_in = 8'd0;
                           msr_in = MSR_IDLE;
                           len_in = RECAL_RESULT_LEN;
                           idx_in = '0;
                           irq_in = 1'b1;
                        end
                        OPC_SENSE_INT: begin
                           msr_in = MSR_RESULT;
                           len_in = SENSE_RESULT_LEN;
                           idx_in = '0;
                           fifo_in[0] = 8'd0;
                           fifo_in[1] = cyl_ff;
                           irq_in = 1'b0;
                        end
                        OPC_READ_ID: begin
                           fifo_in[0] = 8'd0;
                           fifo_in[1] = 8'd0;
                           fifo_in[2] = 8'd0;
                           fifo_in[3] = cyl_ff;
                           fifo_in[4] = head_ff;
                           fifo_in[5] = SECTOR_FIXED;
                           fifo_in[6] = SIZE_CODE_512;
                           len_in = ID_RESULT_LEN;
                           idx_in = '0;
                           msr_in = MSR_RESULT;
                           irq_in = 1'b1;
                        end
                        OPC_SEEK: begin
                           head_in = {2'b00, fwd[1][7:2]};
                           cyl_in  = fwd[2];
                           len_in  = '0;
                           idx_in  = '0;
                           msr_in  = MSR_DONE;
                           irq_in  = 1'b1;
                        end
                        default: begin
                           // bytes completed over a pending result
                           idx_in = '0;
                           len_in = '0;
                           msr_in = MSR_IDLE;
                           result.access_error = 1'b1;
                        end
                     endcase
                  end
               end
            end
            PORT_CCR: ;   // accepted, not stored
            default: result.access_error = 1'b1;
         endcase
      end

      result.irq_level = irq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msr_ff  <= MSR_IDLE;
         dor_ff  <= '0;
         idx_ff  <= '0;
         len_ff  <= '0;
         cyl_ff  <= '0;
         head_ff <= '0;
         irq_ff  <= 1'b0;
         for (int k = 0; k < FIFO_DEPTH; k++) begin
            fifo_ff[k] <= '0;
         end
      end else if (step) begin
         msr_ff  <= msr_in;
         dor_ff  <= dor_in;
         idx_ff  <= idx_in;
         len_ff  <= len_in;
         cyl_ff  <= cyl_in;
         head_ff <= head_in;
         irq_ff  <= irq_in;
         fifo_ff <= fifo_in;
      end
   end

   // every status value keeps the ready bit set
   assert property (@(posedge clock) disable iff (reset) msr_ff[7])
      else $error("main status lost its ready bit");

   // no command or result is longer than read data
   assert property (@(posedge clock) disable iff (reset) len_ff <= MAX_CMD_LEN)
      else $error("fifo length beyond longest command");

   // only read data moves the head without a seek
   assert property (@(posedge clock) disable iff (reset)
      step && !result.dma_start && !(fifo_wr && fwd[0][3:0] == OPC_SEEK)
      |=> $stable(head_ff))
      else $error("head changed outside seek or read data");

endmodule
`default_nettype wire

// ===== hdl/floppy_controller_command_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// floppy_controller_command_fifo
// Host register block of a floppy controller: DOR, MSR, command/result FIFO
// with command execution and DMA sector requests.
// ----------------------------------------------------------------------------
// One host byte access is taken per clock while responses are drained, and
// each gives exactly one response item. An access is captured in an input
// register; once the response register is free or being drained, the
// controller state (MSR, DOR, the 16-byte command/result FIFO, index, length,
// cylinder, head, IRQ) is updated and the response is loaded; sustained
// throughput is one item per cycle while the response side keeps up.
// fcf_core forms the state update combinationally, holding the command decode
// and the 36*cyl + 18*head + sector - 1 address adder.
// Reads return MSR (offset 4), DOR (2) or the next FIFO result byte (5);
// writes go to DOR (2), the FIFO (5) or the accepted-but-ignored CCR (7).
// A read data command with a count of 128 or less reports rsp_dma_start with
// the starting block and sector count. Unknown ports, unknown command codes,
// oversized counts and command bytes completed over a pending result report
// rsp_access_error. rsp_irq_level is the interrupt line after the access.
// No warm-up after reset is needed.
// ----------------------------------------------------------------------------
module floppy_controller_command_fifo
   import fcf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [2:0]  req_port_offset,
   input  wire logic [7:0]  req_write_data,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_irq_level,
   output logic             rsp_dma_start,
   output logic [31:0]      rsp_dma_block,
   output logic [7:0]       rsp_dma_count,
   output logic             rsp_access_error
);

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;

   // response register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff, out_item_in;

   logic    req_take;
   logic    advance;     // item moves from input to response register
   rsp_type core_result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = '{kind: req_kind, port_offset: req_port_offset,
                         write_data: req_write_data};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = core_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   fcf_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_item_ff.read_data;
   assign rsp_irq_level    = out_item_ff.irq_level;
   assign rsp_dma_start    = out_item_ff.dma_start;
   assign rsp_dma_block    = out_item_ff.dma_block;
   assign rsp_dma_count    = out_item_ff.dma_count;
   assign rsp_access_error = out_item_ff.access_error;

   // a DMA request is never flagged as an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dma_start |-> !rsp_access_error)
      else $error("dma request together with access error");

   // without a DMA request the block and count stay clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dma_start |-> rsp_dma_block == '0 && rsp_dma_count == '0)
      else $error("dma fields set without dma start");

   // an item that reaches the response register shows up on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced item missing from response register");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for floppy_controller_command_fifo. Host byte accesses
// go in over the req channel. A behavioral model of the register block
// predicts one reply per access, and a checker compares every reply field by
// field.
// ----------------------------------------------------------------------------
module tb;
   import fcf_pkg::*;

   // Generous watchdog, sized for about 1000 items plus one long reply
   // hold.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;      // idle wait for stray replies at the end
   localparam int MAX_PRINTS   = 40;
   localparam logic [31:0] SECTORS_PER_TRACK = 32'd18;
   localparam logic [31:0] SECTORS_PER_CYL   = 32'd36;   // two heads

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_kind;
   logic [2:0]  req_port_offset;
   logic [7:0]  req_write_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_read_data;
   logic        rsp_irq_level;
   logic        rsp_dma_start;
   logic [31:0] rsp_dma_block;
   logic [7:0]  rsp_dma_count;
   logic        rsp_access_error;

   floppy_controller_command_fifo uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_port_offset  (req_port_offset),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq_level    (rsp_irq_level),
      .rsp_dma_start    (rsp_dma_start),
      .rsp_dma_block    (rsp_dma_block),
      .rsp_dma_count    (rsp_dma_count),
      .rsp_access_error (rsp_access_error)
   );

   // Controller state as the bench believes it to be. It is updated in
   // acceptance order, so it is always current once send_access returns.
   logic [7:0] st_msr;
   logic [7:0] st_dor;
   logic [7:0] st_fifo [FIFO_DEPTH];
   logic [3:0] st_index;
   logic [3:0] st_length;
   logic [7:0] st_cylinder;
   logic [7:0] st_head;
   logic       st_irq;

   rsp_type reply_queue [$];     // predicted replies, oldest first
   int      error_count;
   int      items_sent;
   int      replies_seen;
   int      long_hold;           // nonzero: reply side holds off this many cycles
   logic    idle_enabled;        // random gaps on both sides

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioral model of the register block
   // ------------------------------------------------------------------------

   // Bytes in a command, keyed on the low nibble of its first byte; zero
   // for a code the controller does not know.
   function automatic logic [3:0] command_bytes(input logic [3:0] code);
      case (code)
         OPC_READ_DATA: return MAX_CMD_LEN;
         OPC_RECAL:     return 4'd2;
         OPC_SENSE_INT: return 4'd1;
         OPC_READ_ID:   return 4'd2;
         OPC_SEEK:      return 4'd3;
         default:       return 4'd0;
      endcase
   endfunction

   function automatic void abort_command();
      st_index  = 4'd0;
      st_length = 4'd0;
      st_msr    = MSR_IDLE;
   endfunction

   // ST0..ST2 are always zero, then C, H, R and the 512-byte size code
   function automatic void load_id_bytes();
      st_fifo[0] = 8'd0;
      st_fifo[1] = 8'd0;
      st_fifo[2] = 8'd0;
      st_fifo[3] = st_cylinder;
      st_fifo[4] = st_head;
      st_fifo[5] = SECTOR_FIXED;
      st_fifo[6] = SIZE_CODE_512;
      st_length  = ID_RESULT_LEN;
      st_index   = 4'd0;
      st_msr     = MSR_RESULT;
   endfunction

   function automatic void execute_command(inout rsp_type r);
      case (st_fifo[0][3:0])
         OPC_READ_DATA: begin
            if (st_fifo[6] > MAX_SECTORS) begin
               abort_command();
               r.access_error = 1'b1;
            end else begin
               st_cylinder = st_fifo[2];
               st_head     = st_fifo[3];
               // wraps mod 2^32 when cylinder, head and sector are all zero
               r.dma_start = 1'b1;
               r.dma_block = SECTORS_PER_CYL * 32'(st_cylinder)
                           + SECTORS_PER_TRACK * 32'(st_head)
                           + 32'(st_fifo[4]) - 32'd1;
               r.dma_count = st_fifo[6];
               load_id_bytes();
               st_irq = 1'b1;
            end
         end
         OPC_RECAL: begin
            st_cylinder = 8'd0;
            st_msr      = MSR_IDLE;
            st_length   = RECAL_RESULT_LEN;
            st_index    = 4'd0;
            st_irq      = 1'b1;
         end
         OPC_SENSE_INT: begin
            st_msr     = MSR_RESULT;
            st_length  = SENSE_RESULT_LEN;
            st_index   = 4'd0;
            st_fifo[0] = 8'd0;
            st_fifo[1] = st_cylinder;
            st_irq     = 1'b0;
         end
         OPC_READ_ID: begin
            load_id_bytes();
            st_irq = 1'b1;
         end
         OPC_SEEK: begin
            st_head     = st_fifo[1] >> 2;
            st_cylinder = st_fifo[2];
            st_length   = 4'd0;
            st_index    = 4'd0;
            st_msr      = MSR_DONE;
            st_irq      = 1'b1;
         end
         default: begin
            // bytes written into a pending result complete with a stale code
            abort_command();
            r.access_error = 1'b1;
         end
      endcase
   endfunction

   // One host access: updates the model and returns the reply it must cause
   function automatic rsp_type bus_access_model(input logic kind, input logic [2:0] port,
                                                input logic [7:0] data);
      rsp_type    r;
      logic [3:0] cmd_len;
      r = '0;
      if (kind == KIND_READ) begin
         case (port)
            PORT_MSR: r.read_data = st_msr;
            PORT_DOR: r.read_data = st_dor;
            PORT_FIFO: begin
               r.read_data = st_fifo[st_index];
               st_index = st_index + 4'd1;
               if (st_index >= st_length || st_index == 4'd0) begin
                  st_msr   = MSR_DONE;
                  st_index = 4'd0;
                  st_irq   = 1'b0;
               end
            end
            default: r.access_error = 1'b1;
         endcase
      end else begin
         case (port)
            PORT_DOR: begin
               if (!data[2]) begin
                  st_msr    = MSR_IDLE;
                  st_index  = 4'd0;
                  st_length = 4'd0;
                  st_irq    = 1'b1;
               end
               st_dor = data & DOR_KEEP_MASK;
            end
            PORT_FIFO: begin
               if (st_index == 4'd0) begin
                  cmd_len = command_bytes(data[3:0]);
                  if (cmd_len == 4'd0) begin
                     r.access_error = 1'b1;     // unknown code: byte dropped
                  end else begin
                     st_length = cmd_len;
                     st_msr    = st_msr | MSR_BUSY;
                  end
               end
               if (!r.access_error) begin
                  st_fifo[st_index] = data;
                  st_index = st_index + 4'd1;
                  if (st_index >= st_length || st_index == 4'd0) begin
                     execute_command(r);
                  end
               end
            end
            PORT_CCR: ;                           // taken, not stored
            default: r.access_error = 1'b1;
         endcase
      end
      r.irq_level = st_irq;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (error_count < MAX_PRINTS) begin
         $display("reply %0d: %s got 0x%0h expected 0x%0h", replies_seen, what, got, want);
      end
      error_count++;
   endtask

   // Replies are sampled at the edge where they are accepted
   always @(posedge clock) begin : reply_checker
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_read_data, rsp_irq_level, rsp_dma_start, rsp_dma_block,
                rsp_dma_count, rsp_access_error};
         if (reply_queue.size() == 0) begin
            flag_mismatch("reply with none pending", 32'(got.read_data), 32'd0);
         end else begin
            want = reply_queue.pop_front();
            if (got.read_data !== want.read_data)
               flag_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
            if (got.irq_level !== want.irq_level)
               flag_mismatch("irq_level", 32'(got.irq_level), 32'(want.irq_level));
            if (got.dma_start !== want.dma_start)
               flag_mismatch("dma_start", 32'(got.dma_start), 32'(want.dma_start));
            if (got.dma_block !== want.dma_block)
               flag_mismatch("dma_block", got.dma_block, want.dma_block);
            if (got.dma_count !== want.dma_count)
               flag_mismatch("dma_count", 32'(got.dma_count), 32'(want.dma_count));
            if (got.access_error !== want.access_error)
               flag_mismatch("access_error", 32'(got.access_error),
                             32'(want.access_error));
         end
         replies_seen++;
      end
   end

   // ------------------------------------------------------------------------
   // Reply side: ready with random stall bursts, or one long hold on request
   // ------------------------------------------------------------------------
   initial begin : reply_sink
      int n;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("floppy_controller_command_fifo test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one item and predicts its reply once it is taken. Valid is only
   // lowered at the start of a gap, so a back-to-back item never sees valid
   // dropped and raised within one step.
   task automatic send_access(input logic kind, input logic [2:0] port,
                              input logic [7:0] data);
      int gap;
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_port_offset <= port;
      req_write_data  <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      reply_queue.push_back(bus_access_model(kind, port, data));
      items_sent++;
   endtask

   // Sender goes quiet until every predicted reply has come back
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reply_queue.size() != 0) @(posedge clock);
   endtask

   // Reads the FIFO until the controller is back at a command boundary
   task automatic drain_results();
      int n;
      n = 0;
      while (st_index != 4'd0 && n < FIFO_DEPTH) begin
         send_access(KIND_READ, PORT_FIFO, 8'($urandom));
         n++;
      end
   endtask

   // First nbytes of a command with random operands. The read data count
   // leans on the 128 boundary and on oversized values.
   task automatic issue_command(input logic [3:0] code, input int nbytes);
      logic [7:0] b;
      for (int i = 0; i < nbytes; i++) begin
         b = 8'($urandom);
         if (i == 0) begin
            b[3:0] = code;
         end else if (code == OPC_READ_DATA && i == 6) begin
            case ($urandom_range(0, 7))
               0:       b = MAX_SECTORS;
               1:       b = MAX_SECTORS + 8'd1;
               2:       b = 8'($urandom_range(129, 255));
               default: b = 8'($urandom_range(0, 128));
            endcase
         end
         send_access(KIND_WRITE, PORT_FIFO, b);
      end
   endtask

   function automatic logic [3:0] random_command();
      case ($urandom_range(0, 4))
         0:       return OPC_READ_DATA;
         1:       return OPC_RECAL;
         2:       return OPC_SENSE_INT;
         3:       return OPC_READ_ID;
         default: return OPC_SEEK;
      endcase
   endfunction

   // One random exchange. Most are complete commands with some of their
   // result read back; the rest are register traffic, abandoned commands,
   // unknown codes and raw noise.
   task automatic random_exchange();
      int         pick;
      int         n;
      logic [3:0] code;
      logic [7:0] d;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         drain_results();
         code = random_command();
         issue_command(code, command_bytes(code));
         n = $urandom_range(0, 8);
         repeat (n) begin
            send_access(KIND_READ, ($urandom_range(0, 4) == 0) ? PORT_MSR : PORT_FIFO,
                        8'($urandom));
         end
      end else if (pick < 70) begin
         send_access(1'($urandom), PORT_DOR, 8'($urandom));
      end else if (pick < 80) begin
         // partial command, then a controller reset or stray FIFO traffic
         // (a write into a pending result completes with a stale code)
         code = random_command();
         issue_command(code, $urandom_range(1, command_bytes(code)));
         if ($urandom_range(0, 1) == 0) begin
            d = 8'($urandom);
            d[2] = 1'b0;
            send_access(KIND_WRITE, PORT_DOR, d);
         end else begin
            repeat ($urandom_range(1, 6)) send_access(1'($urandom), PORT_FIFO, 8'($urandom));
         end
      end else if (pick < 88) begin
         drain_results();
         code = 4'($urandom);
         while (command_bytes(code) != 4'd0) code = 4'($urandom);
         send_access(KIND_WRITE, PORT_FIFO, {4'($urandom), code});
      end else begin
         send_access(1'($urandom), 3'($urandom), 8'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Every offset read, every offset but the FIFO written, DOR with bit 2 set and clear
   task automatic test_register_ports();
      for (int p = 0; p < 8; p++) send_access(KIND_READ, 3'(p), 8'hFF);
      send_access(KIND_WRITE, 3'd0, 8'hFF);
      send_access(KIND_WRITE, 3'd1, 8'h00);
      send_access(KIND_WRITE, 3'd3, 8'hFF);
      send_access(KIND_WRITE, PORT_MSR, 8'h00);
      send_access(KIND_WRITE, 3'd6, 8'hFF);
      send_access(KIND_WRITE, PORT_CCR, 8'h00);
      send_access(KIND_WRITE, PORT_DOR, 8'hFF);    // bit 2 set: no reset
      send_access(KIND_WRITE, PORT_DOR, 8'h00);    // bit 2 clear: reset, IRQ up
   endtask

   // Read data at cylinder, head and sector zero: block address wraps to all
   // ones, count at the 128 limit
   task automatic test_read_data_extremes();
      logic [71:0] cmd;
      cmd = {{4'hF, OPC_READ_DATA}, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
             MAX_SECTORS, 8'hFF, 8'hFF};
      for (int i = 0; i < 9; i++) send_access(KIND_WRITE, PORT_FIFO, cmd[71 - 8*i -: 8]);
      send_access(KIND_READ, PORT_MSR, 8'h00);
      send_access(KIND_READ, PORT_FIFO, 8'h00);
   endtask

   task automatic test_random_traffic(input int count);
      int stop;
      stop = items_sent + count;
      while (items_sent < stop) random_exchange();
   endtask

   // Replies held off while items keep coming, so the block fills and
   // drops req_ready
   task automatic test_backpressure();
      int stop;
      idle_enabled = 1'b0;
      long_hold = 300;
      stop = items_sent + 60;
      while (items_sent < stop) random_exchange();
      idle_enabled = 1'b1;
   endtask

   // Sender pauses with the pipeline fully drained between bursts
   task automatic test_drain_pause();
      int stop;
      repeat (2) begin
         stop = items_sent + 20;
         while (items_sent < stop) random_exchange();
         wait_for_replies();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_kind        <= KIND_READ;
      req_port_offset <= 3'd0;
      req_write_data  <= 8'd0;
      idle_enabled = 1'b1;
      long_hold    = 0;

      st_msr      = MSR_IDLE;
      st_dor      = 8'd0;
      st_index    = 4'd0;
      st_length   = 4'd0;
      st_cylinder = 8'd0;
      st_head     = 8'd0;
      st_irq      = 1'b0;
      for (int i = 0; i < FIFO_DEPTH; i++) st_fifo[i] = 8'd0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_register_ports();
      test_read_data_extremes();
      test_random_traffic(700);
      test_backpressure();
      test_drain_pause();
      idle_enabled = 1'b0;          // closing stretch at full rate
      test_random_traffic(100);

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);   // catch any stray reply
      if (error_count == 0) begin
         $display("floppy_controller_command_fifo test passed");
      end else begin
         $display("floppy_controller_command_fifo test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/fcf_pkg.sv
hdl/fcf_lba.sv
hdl/fcf_core.sv
hdl/floppy_controller_command_fifo.sv
sim/tb.sv
